@@ rtl/mwis_pkg.sv @@
// Shared types and constants for the max-weight increasing subsequence block.
`timescale 1ns / 1ps

package mwis_pkg;

  localparam int NUM_HEIGHTS = 1024;
  localparam int SUM_W       = 48;
  localparam int HEIGHT_W    = 11;
  localparam int WEIGHT_W    = 32;

  // Fenwick tree node numbers run 1..NUM_HEIGHTS; memory address is node - 1
  localparam int ADDR_W  = $clog2(NUM_HEIGHTS);
  localparam int IDX_W   = $clog2(NUM_HEIGHTS + 1);
  localparam int WALK_W  = IDX_W + 1;

  // each entry carries the set number it was written in
  localparam int EPOCH_W = 8;
  localparam int MEM_W   = EPOCH_W + SUM_W;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [WEIGHT_W-1:0] weight;
    logic                first_of_set;
  } mwis_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] best_ending_here;
    logic [SUM_W-1:0] best_so_far;
  } mwis_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                clear;
    logic [IDX_W-1:0]    query_idx;
    logic                do_upd;
    logic [IDX_W-1:0]    upd_idx;
    logic [WEIGHT_W-1:0] weight;
  } mwis_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_ADD,
    ST_UPDATE,
    ST_DONE
  } mwis_state_e;

endpackage

@@ rtl/max_weight_increasing_subsequence_top.sv @@
// Top level of the max-weight increasing subsequence block.
`timescale 1ns / 1ps

// Input channel: in_valid_i / in_stall_o carry height, weight and first_of_set.
// first_of_set starts a new set: stored chain totals and running best clear
// before that item. Output channel: out_valid_o / out_stall_i carry the chain
// total ending at the item and the running best of the set, one per item, in
// order. Sums saturate at 2^48 - 1.
// Items are processed one at a time by a Fenwick max tree in a single memory
// (one read and one write port): a prefix walk over the set bits of height - 1,
// then an update walk over the nodes from height to the top. Height zero skips
// both walks and heights above the top skip the update walk. The engine takes
// no new item until the last result has gone into the result register.
// A two-entry queue sits before the engine and a result register after it, so
// inputs keep flowing while a result waits on out_stall_i; once the queue is
// full, in_stall_o rises.
// After reset the engine sweeps the memory before running the first item; the
// queue still accepts two items meanwhile. Every 256th set start costs the
// same sweep when the set number wraps.
module max_weight_increasing_subsequence_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mwis_pkg::mwis_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mwis_pkg::mwis_out_t out_data_o
);
  import mwis_pkg::*;

  logic      cmd_valid;
  logic      cmd_pop;
  mwis_cmd_t cmd;

  mwis_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mwis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/mwis_front.sv @@
// Input side: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module mwis_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mwis_pkg::mwis_in_t in_data_i,
  output logic               cmd_valid_o,
  output mwis_pkg::mwis_cmd_t cmd_o,
  input  logic               cmd_pop_i
);
  import mwis_pkg::*;

  mwis_cmd_t  cmd_new;
  mwis_cmd_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  logic       above_top;

  assign above_top = 32'(in_data_i.height) > NUM_HEIGHTS;

  // prefix query starts at height - 1, clamped to the top node; height zero has no prefix
  always_comb begin
    cmd_new.clear  = in_data_i.first_of_set;
    cmd_new.weight = in_data_i.weight;
    cmd_new.do_upd = (in_data_i.height != '0) && !above_top;
    cmd_new.upd_idx = IDX_W'(in_data_i.height);
    if (in_data_i.height == '0) begin
      cmd_new.query_idx = '0;
    end else if (above_top) begin
      cmd_new.query_idx = IDX_W'(NUM_HEIGHTS);
    end else begin
      cmd_new.query_idx = IDX_W'(in_data_i.height - HEIGHT_W'(1));
    end
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/mwis_back.sv @@
// Back end: Fenwick max-tree query and update over one memory, result register.
`timescale 1ns / 1ps

module mwis_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  mwis_pkg::mwis_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mwis_pkg::mwis_out_t out_data_o
);
  import mwis_pkg::*;

  mwis_state_e state_q, state_d;

  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               have_cmd_q, have_cmd_d;
  logic               rd_pend_q, rd_pend_d;
  logic [SUM_W-1:0]   run_best_q, run_best_d;
  logic               out_valid_q, out_valid_d;

  mwis_cmd_t          cmd_q, cmd_d;
  logic [WALK_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]   best_q, best_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  mwis_out_t          out_data_q, out_data_d;

  logic [MEM_W-1:0]   tree_mem [NUM_HEIGHTS];
  logic [MEM_W-1:0]   mem_rdata_q;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [MEM_W-1:0]   mem_wdata;

  logic [WALK_W-1:0]  lowbit, idx_m1;
  logic [SUM_W-1:0]   rd_val;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [SUM_W-1:0]   new_best;
  logic               out_free;
  logic               last_clr;
  logic               idx_past_top;

  assign lowbit    = idx_q & (~idx_q + WALK_W'(1));
  assign idx_m1    = idx_q - WALK_W'(1);
  assign mem_raddr = idx_m1[ADDR_W-1:0];

  // entries written in an earlier set read as zero
  assign rd_val = (mem_rdata_q[MEM_W-1:SUM_W] == epoch_q) ? mem_rdata_q[SUM_W-1:0] : '0;

  assign sum_wide = {1'b0, best_q} + (SUM_W + 1)'(cmd_q.weight);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign new_best = (total_q > run_best_q) ? total_q : run_best_q;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign last_clr     = (clr_q == ADDR_W'(NUM_HEIGHTS - 1));
  assign idx_past_top = idx_q > WALK_W'(NUM_HEIGHTS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (last_clr) state_d = have_cmd_q ? ST_QUERY : ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.clear && epoch_q == EPOCH_MAX) ? ST_CLEAR : ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (idx_q == '0 && !rd_pend_q) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = cmd_q.do_upd ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        if (idx_past_top && !rd_pend_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_pop_o   = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = {epoch_q, total_q};
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    have_cmd_d  = have_cmd_q;
    rd_pend_d   = 1'b0;
    run_best_d  = run_best_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    best_d      = best_q;
    total_d     = total_q;
    pend_addr_d = pend_addr_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {epoch_q, {SUM_W{1'b0}}};
        clr_d     = clr_q + ADDR_W'(1);
        if (last_clr) begin
          clr_d      = '0;
          have_cmd_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = WALK_W'(cmd_i.query_idx);
          best_d    = '0;
          if (cmd_i.clear) begin
            // wrap of the set number needs a full sweep before the item runs
            epoch_d    = epoch_q + EPOCH_W'(1);
            run_best_d = '0;
            have_cmd_d = (epoch_q == EPOCH_MAX);
          end
        end
      end
      ST_QUERY: begin
        if (rd_pend_q && rd_val > best_q) best_d = rd_val;
        if (idx_q != '0) begin
          mem_re      = 1'b1;
          rd_pend_d   = 1'b1;
          pend_addr_d = mem_raddr;
          idx_d       = idx_q - lowbit;
        end
      end
      ST_ADD: begin
        total_d = sum_sat;
        idx_d   = WALK_W'(cmd_q.upd_idx);
      end
      ST_UPDATE: begin
        // read-modify-write; addresses only rise along the walk, so no hazard
        if (rd_pend_q && rd_val < total_q) begin
          mem_we = 1'b1;
        end
        if (!idx_past_top) begin
          mem_re      = 1'b1;
          rd_pend_d   = 1'b1;
          pend_addr_d = mem_raddr;
          idx_d       = idx_q + lowbit;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_data_d.best_ending_here = total_q;
          out_data_d.best_so_far      = new_best;
          run_best_d                  = new_best;
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      epoch_q     <= '0;
      clr_q       <= '0;
      have_cmd_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      run_best_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      have_cmd_q  <= have_cmd_d;
      rd_pend_q   <= rd_pend_d;
      run_best_q  <= run_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    best_q      <= best_d;
    total_q     <= total_d;
    pend_addr_q <= pend_addr_d;
    out_data_q  <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= tree_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ dv/max_weight_increasing_subsequence_top_test.sv @@
// Self-checking testbench for the max-weight increasing subsequence block.
`timescale 1ns / 1ps

module max_weight_increasing_subsequence_top_test;
  import mwis_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int NUM_DIR     = 21;
  localparam int HEIGHT_TOP  = (1 << HEIGHT_W) - 1;

  typedef struct packed {
    mwis_in_t  item;
    logic      checked;
    mwis_out_t want;
  } dir_row_t;

  // checked rows carry totals worked out by hand; the rest go through chain_step
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{11'd5,    32'd10,         1'b0}, 1'b1, '{48'd10,          48'd10}},
    '{'{11'd3,    32'd7,          1'b0}, 1'b1, '{48'd7,           48'd10}},
    '{'{11'd7,    32'd1,          1'b0}, 1'b1, '{48'd11,          48'd11}},
    '{'{11'd0,    32'd100,        1'b0}, 1'b1, '{48'd100,         48'd100}},
    '{'{11'd2047, 32'd1,          1'b0}, 1'b1, '{48'd12,          48'd100}},
    '{'{11'd1025, 32'd0,          1'b0}, 1'b1, '{48'd11,          48'd100}},
    '{'{11'd1024, 32'hFFFFFFFF,   1'b0}, 1'b1, '{48'h10000000A,   48'h10000000A}},
    '{'{11'd1024, 32'd5,          1'b0}, 1'b1, '{48'd16,          48'h10000000A}},
    '{'{11'd2047, 32'd0,          1'b0}, 1'b1, '{48'h10000000A,   48'h10000000A}},
    '{'{11'd1,    32'd0,          1'b1}, 1'b1, '{48'd0,           48'd0}},
    '{'{11'd2,    32'd0,          1'b0}, 1'b1, '{48'd0,           48'd0}},
    '{'{11'd1024, 32'h80000000,   1'b0}, 1'b1, '{48'h80000000,    48'h80000000}},
    '{'{11'd1,    32'hFFFFFFFF,   1'b1}, 1'b1, '{48'hFFFFFFFF,    48'hFFFFFFFF}},
    '{'{11'd1024, 32'hFFFFFFFF,   1'b0}, 1'b1, '{48'h1FFFFFFFE,   48'h1FFFFFFFE}},
    '{'{11'd512,  32'h55555555,   1'b0}, 1'b1, '{48'h155555554,   48'h1FFFFFFFE}},
    '{'{11'd513,  32'hAAAAAAAA,   1'b0}, 1'b0, '{48'd0,           48'd0}},
    '{'{11'd1023, 32'd1,          1'b0}, 1'b0, '{48'd0,           48'd0}},
    '{'{11'd0,    32'hFFFFFFFF,   1'b1}, 1'b1, '{48'hFFFFFFFF,    48'hFFFFFFFF}},
    '{'{11'd1536, 32'd3,          1'b0}, 1'b1, '{48'd3,           48'hFFFFFFFF}},
    '{'{11'd1,    32'd1,          1'b0}, 1'b1, '{48'd1,           48'hFFFFFFFF}},
    '{'{11'd1024, 32'd1,          1'b0}, 1'b1, '{48'd2,           48'hFFFFFFFF}}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  mwis_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  mwis_out_t out_data;

  // predictor state: best chain total per height, best of the current set
  logic [SUM_W-1:0] chain_best [NUM_HEIGHTS];
  logic [SUM_W-1:0] set_best;

  mwis_out_t pending_totals [$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        items_sent   = 0;
  int        sets_sent    = 0;
  int        cycle_count  = 0;
  int        send_calm    = 0;

  max_weight_increasing_subsequence_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one item through the chain store; returns the chain total and set best
  function automatic mwis_out_t chain_step(mwis_in_t item);
    logic [SUM_W-1:0] below;
    logic [SUM_W:0]   sum;
    logic [SUM_W-1:0] total;
    int               lim;
    mwis_out_t        res;
    if (item.first_of_set) begin
      foreach (chain_best[k]) chain_best[k] = '0;
      set_best = '0;
    end
    below = '0;
    // heights above the store see every entry; height zero sees none
    lim = (int'(item.height) > NUM_HEIGHTS) ? NUM_HEIGHTS : int'(item.height) - 1;
    for (int k = 0; k < lim; k++)
      if (chain_best[k] > below) below = chain_best[k];
    sum = {1'b0, below} + item.weight;
    total = (sum > {1'b0, SUM_MAX}) ? SUM_MAX : sum[SUM_W-1:0];
    if (item.height >= 1 && int'(item.height) <= NUM_HEIGHTS) begin
      if (total > chain_best[item.height - 1]) chain_best[item.height - 1] = total;
    end
    if (total > set_best) set_best = total;
    res.best_ending_here = total;
    res.best_so_far      = set_best;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic send_item(mwis_in_t item, logic checked, mwis_out_t want);
    mwis_out_t pred;
    int        n;
    if (send_calm > 0) begin
      send_calm--;
      n = 0;
    end else begin
      n = idle_len();
      if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(20, 60);
    end
    @(negedge clk);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = chain_step(item);
    items_sent++;
    pending_totals.insert(pending_totals.size(), checked ? want : pred);
  endtask

  // drop valid after the last transfer, then wait for every result
  task automatic drain_pending();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_totals.size() != 0) @(negedge clk);
  endtask

  // a set: mostly short, some medium, a few long; heights over the whole range
  // or packed into a window so that long chains form
  task automatic send_random_set();
    int                  len;
    int                  lo;
    int                  hi;
    int                  r;
    logic [HEIGHT_W-1:0] used [$];
    mwis_in_t            item;
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(1, 2);
    else if (r < 98) len = $urandom_range(3, 8);
    else len = $urandom_range(20, 40);
    if ($urandom_range(0, 1)) begin
      lo = 1;
      hi = NUM_HEIGHTS;
    end else begin
      lo = $urandom_range(1, NUM_HEIGHTS - 100);
      hi = lo + $urandom_range(20, 99);
    end
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) item.height = '0;
      else if (r < 8) item.height = HEIGHT_W'($urandom_range(NUM_HEIGHTS + 1, HEIGHT_TOP));
      else if (r < 13 && used.size() != 0)
        item.height = used[$urandom_range(0, used.size() - 1)];
      else item.height = HEIGHT_W'($urandom_range(lo, hi));
      used.insert(used.size(), item.height);
      r = $urandom_range(0, 99);
      if (r < 15) item.weight = '0;
      else if (r < 25) item.weight = '1;
      else if (r < 60) item.weight = WEIGHT_W'($urandom_range(0, 255));
      else item.weight = $urandom;
      // now and then a set runs on without the clear
      item.first_of_set = (i == 0) && ($urandom_range(0, 19) != 0);
      send_item(item, 1'b0, '0);
    end
  endtask

  // sender
  initial begin
    bit mid_drained;
    mid_drained = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    foreach (chain_best[k]) chain_best[k] = '0;
    set_best = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < NUM_DIR; i++)
      send_item(DIR_ROWS[i].item, DIR_ROWS[i].checked, DIR_ROWS[i].want);
    drain_pending();
    // enough sets to wrap the block's set counter at least once
    while ((items_sent < 850 || sets_sent < 290) && items_sent < 1400) begin
      send_random_set();
      sets_sent++;
      if (!mid_drained && items_sent >= 450) begin
        drain_pending();
        mid_drained = 1'b1;
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    drain_pending();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver stall pattern, with two long hold-offs that back up the input
  initial begin
    int n;
    int calm;
    int hold_idx;
    calm      = 0;
    hold_idx  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_idx < 2 && results_seen >= (hold_idx == 0 ? 120 : 600)) begin
        hold_idx++;
        n = 400;
      end else if (calm > 0) begin
        calm--;
        n = 0;
      end else begin
        n = idle_len();
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 80);
      end
      out_stall = (n != 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    mwis_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer %h", out_data));
      end else begin
        want = pending_totals.pop_front();
        if (out_data.best_ending_here !== want.best_ending_here)
          report_mismatch($sformatf("best_ending_here %h, want %h",
                                    out_data.best_ending_here, want.best_ending_here));
        if (out_data.best_so_far !== want.best_so_far)
          report_mismatch($sformatf("best_so_far %h, want %h",
                                    out_data.best_so_far, want.best_so_far));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
